// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks sampled on a rising clock edge.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is off while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that also holds while reset is high
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/urb_pkg.sv -----
// ---------------------------------------------------------------------------
// urb_pkg
// Sizes, codes and types for the UART ring buffers with flush timer.
// ---------------------------------------------------------------------------
`default_nettype none

package urb_pkg;

   localparam int BUF_DEPTH     = 256;
   localparam int HW_FIFO_DEPTH = 16;
   localparam int PTR_W         = $clog2(BUF_DEPTH);
   // most bytes one drain may send
   localparam int DRAIN_MAX     = (HW_FIFO_DEPTH < 16) ? HW_FIFO_DEPTH : 16;
   localparam int LIM_W         = $clog2(DRAIN_MAX + 1);

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [7:0]       data_type;
   typedef logic [LIM_W-1:0] lim_type;

   localparam logic [2:0] ACT_TX_PUT   = 3'd0;
   localparam logic [2:0] ACT_TICK     = 3'd1;
   localparam logic [2:0] ACT_FLUSH    = 3'd2;
   localparam logic [2:0] ACT_TX_READY = 3'd3;
   localparam logic [2:0] ACT_RX_BYTE  = 3'd4;
   localparam logic [2:0] ACT_RX_READ  = 3'd5;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_UART   = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_TX_FULL  = 2'd1;
   localparam logic [1:0] STAT_RX_OVF   = 2'd2;
   localparam logic [1:0] STAT_RX_EMPTY = 2'd3;

   localparam logic CSR_FLUSH_DELAY = 1'b0;
   localparam logic CSR_CMD_MODE    = 1'b1;

   localparam data_type CHAR_CR         = 8'd13;
   localparam data_type CHAR_LF         = 8'd10;
   localparam data_type FLUSH_DELAY_RST = 8'd10;

endpackage

`default_nettype wire

// ----- rtl/core/urb_ram.sv -----
// ---------------------------------------------------------------------------
// urb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module urb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/uart_ring_buffers_with_flush_timer.sv -----
// ---------------------------------------------------------------------------
// uart_ring_buffers_with_flush_timer
// Transmit and receive byte ring buffers with a flush countdown and drain.
//
//   channel   ports                 handshake
//   request   req_*, start, busy    taken on start && !busy
//   result    rsp_*                 rsp_strobe for one cycle, no back-pressure
//   config    csr_*                 written on csr_we
//
// A request is taken on accept; its first result shows the cycle after.
// A drain sends one byte per cycle, up to 16, through the single read port
// of the transmit store; busy stays high until the last read is issued.
// Every other request gives one result and leaves busy low.
// Reset clears pointers, countdown, limit and strobe; stores are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_ring_buffers_with_flush_timer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [2:0]          req_action,
   input  wire urb_pkg::data_type   req_data_in,
   input  wire logic [4:0]          req_uart_space,
   output logic                     rsp_strobe,
   output logic [1:0]               rsp_kind,
   output urb_pkg::data_type        rsp_data_out,
   output logic [1:0]               rsp_status,
   output logic                     rsp_line_end,
   output logic                     rsp_last,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire urb_pkg::data_type   csr_wdata
);

   import urb_pkg::*;

`include "assert_macros.svh"

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_TX   = 2'd1;
   localparam logic [1:0] SRC_RX   = 2'd2;

   logic     state_ff, state_in;
   ptr_type  tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   ptr_type  rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   data_type cnt_ff, cnt_in;
   data_type delay_ff, delay_in;
   logic     cmd_mode_ff, cmd_mode_in;
   lim_type  lim_ff, lim_in;

   logic       out_vld_ff, out_vld_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic [1:0] out_src_ff, out_src_in;
   logic [1:0] out_status_ff, out_status_in;
   logic       out_le_ff, out_le_in;
   logic       out_last_ff, out_last_in;

   ptr_type  tx_wr_nx, tx_rd_nx, rx_wr_nx, rx_rd_nx;
   logic     tx_full, tx_empty, rx_full, rx_empty;
   lim_type  lim_req, lim_cur;
   logic     drain_go, drain_last, do_drain, accept, le;
   logic     tx_we, rx_we;
   data_type tx_q, rx_q;

   urb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_wr_ff),
      .wr_data (req_data_in),
      .rd_addr (tx_rd_ff),
      .rd_data (tx_q)
   );

   urb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_wr_ff),
      .wr_data (req_data_in),
      .rd_addr (rx_rd_ff),
      .rd_data (rx_q)
   );

   assign busy   = (state_ff == ST_DRAIN);
   assign accept = start && !busy;

   always_comb begin
      tx_wr_nx = tx_wr_ff + ptr_type'(1);
      tx_rd_nx = tx_rd_ff + ptr_type'(1);
      rx_wr_nx = rx_wr_ff + ptr_type'(1);
      rx_rd_nx = rx_rd_ff + ptr_type'(1);
      // one slot stays free so full and empty differ
      tx_full  = (tx_wr_nx == tx_rd_ff);
      tx_empty = (tx_rd_ff == tx_wr_ff);
      rx_full  = (rx_wr_nx == rx_rd_ff);
      rx_empty = (rx_rd_ff == rx_wr_ff);

      lim_req = (req_uart_space > 5'(DRAIN_MAX)) ? LIM_W'(DRAIN_MAX)
                                                 : LIM_W'(req_uart_space);
      lim_cur    = (state_ff == ST_DRAIN) ? lim_ff : lim_req;
      drain_go   = (lim_cur != '0) && !tx_empty;
      drain_last = (lim_cur == LIM_W'(1)) || (tx_rd_nx == tx_wr_ff);

      le = cmd_mode_ff && ((req_data_in == CHAR_CR) || (req_data_in == CHAR_LF));

      state_in    = state_ff;
      tx_wr_in    = tx_wr_ff;
      tx_rd_in    = tx_rd_ff;
      rx_wr_in    = rx_wr_ff;
      rx_rd_in    = rx_rd_ff;
      cnt_in      = cnt_ff;
      delay_in    = delay_ff;
      cmd_mode_in = cmd_mode_ff;
      lim_in      = lim_ff;
      do_drain    = 1'b0;
      tx_we       = 1'b0;
      rx_we       = 1'b0;

      out_vld_in    = 1'b0;
      out_kind_in   = KIND_STATUS;
      out_src_in    = SRC_NONE;
      out_status_in = STAT_OK;
      out_le_in     = 1'b0;
      out_last_in   = 1'b1;

      if (csr_we) begin
         unique case (csr_index)
            CSR_FLUSH_DELAY: delay_in    = csr_wdata;
            CSR_CMD_MODE:    cmd_mode_in = csr_wdata[0];
            default:         ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               out_vld_in = 1'b1;
               unique case (req_action)
                  ACT_TX_PUT: begin
                     if (tx_full) begin
                        out_status_in = STAT_TX_FULL;
                     end else begin
                        tx_we    = 1'b1;
                        tx_wr_in = tx_wr_nx;
                        cnt_in   = delay_ff;
                     end
                  end
                  ACT_TICK: begin
                     if (cnt_ff != '0) begin
                        cnt_in   = cnt_ff - 8'd1;
                        do_drain = (cnt_ff == 8'd1);
                     end
                  end
                  ACT_FLUSH: begin
                     do_drain = 1'b1;
                     cnt_in   = '0;
                  end
                  ACT_TX_READY: do_drain = 1'b1;
                  ACT_RX_BYTE: begin
                     out_le_in = le;
                     if (rx_full) begin
                        out_status_in = STAT_RX_OVF;
                     end else begin
                        rx_we    = 1'b1;
                        rx_wr_in = rx_wr_nx;
                     end
                  end
                  ACT_RX_READ: begin
                     if (rx_empty) begin
                        out_status_in = STAT_RX_EMPTY;
                     end else begin
                        out_kind_in = KIND_READ;
                        out_src_in  = SRC_RX;
                        rx_rd_in    = rx_rd_nx;
                     end
                  end
                  default: ;
               endcase
               // first byte of a drain is read in the accept cycle
               if (do_drain && drain_go) begin
                  out_kind_in = KIND_UART;
                  out_src_in  = SRC_TX;
                  out_last_in = drain_last;
                  tx_rd_in    = tx_rd_nx;
                  lim_in      = lim_cur - LIM_W'(1);
                  if (!drain_last) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            out_vld_in  = 1'b1;
            out_kind_in = KIND_UART;
            out_src_in  = SRC_TX;
            out_last_in = drain_last;
            tx_rd_in    = tx_rd_nx;
            lim_in      = lim_cur - LIM_W'(1);
            if (drain_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tx_wr_ff    <= '0;
         tx_rd_ff    <= '0;
         rx_wr_ff    <= '0;
         rx_rd_ff    <= '0;
         cnt_ff      <= '0;
         delay_ff    <= FLUSH_DELAY_RST;
         cmd_mode_ff <= 1'b1;
         lim_ff      <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tx_wr_ff    <= tx_wr_in;
         tx_rd_ff    <= tx_rd_in;
         rx_wr_ff    <= rx_wr_in;
         rx_rd_ff    <= rx_rd_in;
         cnt_ff      <= cnt_in;
         delay_ff    <= delay_in;
         cmd_mode_ff <= cmd_mode_in;
         lim_ff      <= lim_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_src_ff    <= out_src_in;
      out_status_ff <= out_status_in;
      out_le_ff     <= out_le_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      case (out_src_ff)
         SRC_TX:  rsp_data_out = tx_q;
         SRC_RX:  rsp_data_out = rx_q;
         default: rsp_data_out = '0;
      endcase
   end

   assign rsp_strobe   = out_vld_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_line_end = out_le_ff;
   assign rsp_last     = out_last_ff;

   `ASSERT_CLK_RST(a_request_answered, clock, reset, accept |=> rsp_strobe, "request gave no result")
   `ASSERT_CLK_RST(a_burst_contiguous, clock, reset, rsp_strobe && !rsp_last |=> rsp_strobe, "gap in drain burst")
   `ASSERT_CLK_RST(a_drain_emits, clock, reset, busy |=> (rsp_strobe && rsp_kind == KIND_UART), "drain cycle sent no byte")

endmodule

`default_nettype wire

// ----- verif/tb_uart_ring_buffers_with_flush_timer.sv -----
// ---------------------------------------------------------------------------
// tb_uart_ring_buffers_with_flush_timer
// Drives transmit puts, ticks, flushes, transmit-ready events, received bytes
// and reads into the ring buffer block. A behavioral model of both rings and
// the flush countdown predicts every result, and each result is checked
// field by field in arrival order.
// ---------------------------------------------------------------------------

module tb_uart_ring_buffers_with_flush_timer;

   import urb_pkg::*;

   localparam logic [2:0] ACT_SPARE_A  = 3'd6;
   localparam logic [2:0] ACT_SPARE_B  = 3'd7;
   localparam int         QUIET_LIMIT  = 2000;
   localparam int         SETTLE_WAIT  = 4;
   localparam int         PHASE_ITEMS  = 10;
   localparam int         LONG_DELAY   = 12;

   typedef struct packed {
      logic [1:0] kind;
      data_type   data;
      logic [1:0] status;
      logic       line_end;
      logic       last;
   } rsp_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       start          = 1'b0;
   logic [2:0] req_action     = ACT_TICK;
   data_type   req_data_in    = '0;
   logic [4:0] req_uart_space = '0;
   logic       csr_we         = 1'b0;
   logic       csr_index      = CSR_FLUSH_DELAY;
   data_type   csr_wdata      = '0;

   logic       busy;
   logic       rsp_strobe;
   logic [1:0] rsp_kind;
   data_type   rsp_data_out;
   logic [1:0] rsp_status;
   logic       rsp_line_end;
   logic       rsp_last;

   // model state
   data_type   tx_mem [BUF_DEPTH];
   data_type   rx_mem [BUF_DEPTH];
   ptr_type    tx_wr        = '0;
   ptr_type    tx_rd        = '0;
   ptr_type    rx_wr        = '0;
   ptr_type    rx_rd        = '0;
   data_type   countdown    = '0;
   data_type   delay_reg    = FLUSH_DELAY_RST;
   logic       cmd_mode_reg = 1'b1;

   rsp_type    awaited_rsp [$];
   rsp_type    head_rsp;
   int         error_count  = 0;
   int         req_count    = 0;
   int         burst_left   = 0;
   int         quiet_cycles = 0;

   uart_ring_buffers_with_flush_timer dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_data_in    (req_data_in),
      .req_uart_space (req_uart_space),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_line_end   (rsp_line_end),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------- prediction ----------------

   function automatic void queue_rsp(logic [1:0] kind, data_type data, logic [1:0] status,
                                     logic line_end);
      rsp_type r;
      r.kind     = kind;
      r.data     = data;
      r.status   = status;
      r.line_end = line_end;
      r.last     = 1'b0;
      awaited_rsp.push_back(r);
   endfunction

   function automatic int ring_drain(logic [4:0] space);
      int lim;
      int n;
      lim = (int'(space) > DRAIN_MAX) ? DRAIN_MAX : int'(space);
      n = 0;
      while (n < lim && tx_rd != tx_wr) begin
         queue_rsp(KIND_UART, tx_mem[tx_rd], STAT_OK, 1'b0);
         tx_rd = tx_rd + 1'b1;
         n++;
      end
      return n;
   endfunction

   function automatic void ring_predict(logic [2:0] act, data_type d, logic [4:0] space);
      int      n;
      logic    le;
      rsp_type tail;
      n = 0;
      case (act)
         ACT_TX_PUT: begin
            if (ptr_type'(tx_wr + 1'b1) == tx_rd) begin
               queue_rsp(KIND_STATUS, '0, STAT_TX_FULL, 1'b0);
            end else begin
               tx_mem[tx_wr] = d;
               tx_wr = tx_wr + 1'b1;
               countdown = delay_reg;
               queue_rsp(KIND_STATUS, '0, STAT_OK, 1'b0);
            end
            n = 1;
         end
         ACT_TICK: begin
            if (countdown != 0) begin
               countdown = countdown - 1'b1;
               if (countdown == 0) n = ring_drain(space);
            end
         end
         ACT_FLUSH: begin
            n = ring_drain(space);
            countdown = '0;
         end
         ACT_TX_READY: n = ring_drain(space);
         ACT_RX_BYTE: begin
            // line end is reported even when the byte is dropped
            le = cmd_mode_reg && (d == CHAR_CR || d == CHAR_LF);
            if (ptr_type'(rx_wr + 1'b1) == rx_rd) begin
               queue_rsp(KIND_STATUS, '0, STAT_RX_OVF, le);
            end else begin
               rx_mem[rx_wr] = d;
               rx_wr = rx_wr + 1'b1;
               queue_rsp(KIND_STATUS, '0, STAT_OK, le);
            end
            n = 1;
         end
         ACT_RX_READ: begin
            if (rx_rd != rx_wr) begin
               queue_rsp(KIND_READ, rx_mem[rx_rd], STAT_OK, 1'b0);
               rx_rd = rx_rd + 1'b1;
            end else begin
               queue_rsp(KIND_STATUS, '0, STAT_RX_EMPTY, 1'b0);
            end
            n = 1;
         end
         default: ;
      endcase
      if (n == 0) queue_rsp(KIND_STATUS, '0, STAT_OK, 1'b0);
      tail = awaited_rsp.pop_back();
      tail.last = 1'b1;
      awaited_rsp.push_back(tail);
   endfunction

   // ---------------- result checking ----------------

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_rsp.size() == 0) begin
            $error("result with no request pending: kind %0d data %0d", rsp_kind,
                   rsp_data_out);
            error_count++;
         end else begin
            head_rsp = awaited_rsp.pop_front();
            check_field("kind", head_rsp.kind, rsp_kind);
            check_field("data_out", head_rsp.data, rsp_data_out);
            check_field("status", head_rsp.status, rsp_status);
            check_field("line_end", head_rsp.line_end, rsp_line_end);
            check_field("last", head_rsp.last, rsp_last);
         end
      end
   end

   // watchdog: cycles with neither a request taken nor a result out
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- stimulus helpers ----------------

   // leaves start high so back-to-back requests follow without a gap
   task automatic send_req(logic [2:0] act, data_type d, logic [4:0] space);
      start          <= 1'b1;
      req_action     <= act;
      req_data_in    <= d;
      req_uart_space <= space;
      @(posedge clock);
      while (busy) @(posedge clock);
      ring_predict(act, d, space);
      req_count++;
   endtask

   task automatic hold_off(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_paced(logic [2:0] act, data_type d, logic [4:0] space);
      if (burst_left == 0) begin
         hold_off($urandom_range(1, 10));
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      send_req(act, d, space);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, data_type val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_FLUSH_DELAY) delay_reg = val;
      else cmd_mode_reg = val[0];
   endtask

   function automatic data_type pick_byte();
      case ($urandom_range(0, 7))
         0: return CHAR_CR;
         1: return CHAR_LF;
         default: return data_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [4:0] pick_space();
      return 5'($urandom_range(0, 16));
   endfunction

   // ---------------- tests ----------------

   task automatic test_basic_requests();
      // empty buffers, zero countdown, spare action codes
      send_req(ACT_RX_READ, 8'h00, 5'd0);
      send_req(ACT_TX_READY, 8'h00, 5'd16);
      send_req(ACT_FLUSH, 8'hFF, 5'd16);
      send_req(ACT_TICK, 8'h00, 5'd16);
      send_req(ACT_SPARE_A, 8'h55, 5'd16);
      send_req(ACT_SPARE_B, 8'hAA, 5'd0);
      settle();
      write_csr(CSR_FLUSH_DELAY, 8'd3);
      send_req(ACT_TX_PUT, 8'h00, 5'd0);
      send_req(ACT_TX_PUT, 8'hFF, 5'd0);
      send_req(ACT_TX_PUT, 8'hA5, 5'd16);
      send_req(ACT_TX_READY, 8'h00, 5'd0);
      send_req(ACT_TX_READY, 8'h00, 5'd1);
      // ready leaves the countdown alone: third tick drains the rest
      send_req(ACT_TICK, 8'h00, 5'd16);
      send_req(ACT_TICK, 8'h00, 5'd16);
      send_req(ACT_TICK, 8'h00, 5'd16);
      send_req(ACT_TX_PUT, 8'h3C, 5'd0);
      send_req(ACT_TX_PUT, 8'hC3, 5'd0);
      // flush with no room clears the countdown, so the tick does nothing
      send_req(ACT_FLUSH, 8'h00, 5'd0);
      send_req(ACT_TICK, 8'h00, 5'd16);
      send_req(ACT_TX_READY, 8'h00, 5'd16);
      send_req(ACT_RX_BYTE, CHAR_CR, 5'd0);
      send_req(ACT_RX_BYTE, CHAR_LF, 5'd0);
      send_req(ACT_RX_BYTE, 8'h00, 5'd0);
      send_req(ACT_RX_BYTE, 8'hFF, 5'd0);
      repeat (5) send_req(ACT_RX_READ, 8'h00, 5'd0);
   endtask

   task automatic test_command_mode_off();
      settle();
      write_csr(CSR_CMD_MODE, 1'b0);
      send_req(ACT_RX_BYTE, CHAR_CR, 5'd0);
      send_req(ACT_RX_BYTE, CHAR_LF, 5'd0);
      send_req(ACT_RX_READ, 8'h00, 5'd0);
      send_req(ACT_RX_READ, 8'h00, 5'd0);
      settle();
      write_csr(CSR_CMD_MODE, 1'b1);
   endtask

   task automatic test_zero_flush_delay();
      settle();
      write_csr(CSR_FLUSH_DELAY, 8'd0);
      send_req(ACT_TX_PUT, 8'h12, 5'd0);
      send_req(ACT_TX_PUT, 8'h34, 5'd0);
      send_req(ACT_TICK, 8'h00, 5'd16);
      send_req(ACT_TICK, 8'h00, 5'd16);
      send_req(ACT_TX_READY, 8'h00, 5'd16);
   endtask

   task automatic test_long_flush_delay();
      settle();
      write_csr(CSR_FLUSH_DELAY, data_type'(LONG_DELAY));
      repeat (3) send_req(ACT_TX_PUT, pick_byte(), pick_space());
      repeat (LONG_DELAY) send_paced(ACT_TICK, pick_byte(), 5'd16);
   endtask

   task automatic test_random_traffic();
      int   phase;
      int   first;
      int   n;
      int   sel;
      logic drained_once;
      drained_once = 1'b0;
      for (phase = 0; phase < 4; phase++) begin
         settle();
         write_csr(CSR_FLUSH_DELAY, (phase == 0) ? 8'd1 : data_type'($urandom_range(2, 8)));
         write_csr(CSR_CMD_MODE, (phase == 1) ? 1'b0 : 1'b1);
         first = req_count;
         while (req_count - first < PHASE_ITEMS) begin
            if (phase == 2 && !drained_once && req_count - first >= PHASE_ITEMS / 2) begin
               settle();
               drained_once = 1'b1;
            end
            sel = $urandom_range(0, 99);
            n   = $urandom_range(1, 5);
            if (sel < 40) begin
               repeat (n) send_paced(ACT_TX_PUT, pick_byte(), pick_space());
               if ($urandom_range(0, 3) == 0)
                  send_paced(ACT_TX_READY, pick_byte(), pick_space());
               // sometimes one tick short, leaving the countdown armed
               repeat (int'(delay_reg) - int'($urandom_range(0, 3) == 0))
                  send_paced(ACT_TICK, pick_byte(), pick_space());
            end else if (sel < 70) begin
               repeat (n) send_paced(ACT_RX_BYTE, pick_byte(), pick_space());
               repeat (n + $urandom_range(0, 1))
                  send_paced(ACT_RX_READ, pick_byte(), pick_space());
            end else begin
               send_paced(3'($urandom_range(0, 7)), pick_byte(), pick_space());
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_requests();
      test_command_mode_off();
      test_zero_flush_delay();
      test_long_flush_delay();
      test_random_traffic();
      settle();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
